// File: rtl/core/sfpc_pkg.sv
// Shared constants, widths and types for the sensor frustum point cull block.
// Used by every module in rtl/core; depends on nothing else.
package sfpc_pkg;

    localparam int COORD_BITS    = 24;
    localparam int ROT_FRAC_BITS = 16;
    localparam int ROT_BITS      = ROT_FRAC_BITS + 2;
    localparam int ROW_BITS      = 3 * ROT_BITS;
    localparam int TAN_BITS      = 24;
    localparam int TAN_FRAC_BITS = 16;
    localparam int FOV_BITS      = 2 * TAN_BITS;
    localparam int CFG_DATA_BITS = (ROW_BITS > FOV_BITS) ? ROW_BITS : FOV_BITS;
    localparam int CFG_IDX_BITS  = 3;

    localparam int PROD_BITS = ROT_BITS + COORD_BITS;
    localparam int ACC_BITS  = PROD_BITS + 2;
    localparam int RND_BITS  = ACC_BITS - ROT_FRAC_BITS;
    localparam int SENS_BITS = RND_BITS + 1;
    localparam int MAG_BITS  = SENS_BITS - 1;
    localparam int SQ_BITS   = 2 * MAG_BITS;
    localparam int XY2_BITS  = SQ_BITS + 1;
    localparam int R2_BITS   = SQ_BITS + 2;
    localparam int LIM_BITS  = COORD_BITS - 1;
    localparam int LIM2_BITS = 2 * LIM_BITS;
    localparam int HT_BITS   = TAN_BITS + MAG_BITS;
    localparam int TV2_BITS  = 2 * TAN_BITS;
    localparam int XY2_LO    = (XY2_BITS + 1) / 2;
    localparam int XY2_HI    = XY2_BITS - XY2_LO;
    localparam int PP_LO     = XY2_LO + TAN_BITS;
    localparam int PP_HI     = XY2_HI + TAN_BITS;
    localparam int RHS_BITS  = XY2_BITS + TV2_BITS;

    localparam logic [ROT_BITS-1:0]  ROT_ONE     = ROT_BITS'(1) << ROT_FRAC_BITS;
    localparam logic [ROW_BITS-1:0]  ROW_X_RESET = ROW_BITS'(ROT_ONE);
    localparam logic [ROW_BITS-1:0]  ROW_Y_RESET = ROW_BITS'(ROT_ONE) << ROT_BITS;
    localparam logic [ROW_BITS-1:0]  ROW_Z_RESET = ROW_BITS'(ROT_ONE) << (2 * ROT_BITS);
    localparam logic [LIM_BITS-1:0]  LIM_MAX     = {LIM_BITS{1'b1}};
    localparam logic [LIM2_BITS-1:0] LIM2_RESET  = LIM2_BITS'(LIM_MAX) * LIM2_BITS'(LIM_MAX);
    localparam logic [TAN_BITS-1:0]  TAN_ONE     = TAN_BITS'(1) << TAN_FRAC_BITS;
    localparam logic [TV2_BITS-1:0]  TV2_RESET   = TV2_BITS'(1) << (2 * TAN_FRAC_BITS);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_ROT_X   = 3'd0,
        REG_ROT_Y   = 3'd1,
        REG_ROT_Z   = 3'd2,
        REG_SHIFT_X = 3'd3,
        REG_SHIFT_Y = 3'd4,
        REG_SHIFT_Z = 3'd5,
        REG_REACH   = 3'd6,
        REG_FOV     = 3'd7
    } cfg_idx_t;

    typedef enum logic [2:0] {
        RSN_KEEP   = 3'd0,
        RSN_RANGE  = 3'd1,
        RSN_BEHIND = 3'd2,
        RSN_HFOV   = 3'd3,
        RSN_VFOV   = 3'd4
    } reason_t;

    typedef struct packed {
        logic [2:0][2:0][ROT_BITS-1:0] rot;
        logic [2:0][COORD_BITS-1:0]    shift;
        logic [LIM2_BITS-1:0]          lim2;
        logic [TAN_BITS-1:0]           tan_h;
        logic [TV2_BITS-1:0]           tv2;
    } cfg_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
    } point_t;

    typedef struct packed {
        logic signed [SENS_BITS-1:0] x;
        logic signed [SENS_BITS-1:0] y;
        logic signed [SENS_BITS-1:0] z;
        point_t                      pt;
    } sens_t;

endpackage

// File: rtl/core/sfpc_cfg.sv
// Configuration register file of the frustum cull block.
// Precomputes the squared range limit and squared vertical tangent on write; uses sfpc_pkg.
module sfpc_cfg
    import sfpc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    output cfg_t                     cfg
);

    cfg_t                 cfg_reg;
    logic [LIM_BITS-1:0]  lim_next;
    logic [TAN_BITS-1:0]  tan_v_next;

    assign lim_next   = cfg_data[LIM_BITS-1:0];
    assign tan_v_next = cfg_data[FOV_BITS-1:TAN_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rot[0] <= ROW_X_RESET;
            cfg_reg.rot[1] <= ROW_Y_RESET;
            cfg_reg.rot[2] <= ROW_Z_RESET;
            cfg_reg.shift  <= '0;
            cfg_reg.lim2   <= LIM2_RESET;
            cfg_reg.tan_h  <= TAN_ONE;
            cfg_reg.tv2    <= TV2_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_ROT_X:   cfg_reg.rot[0]   <= cfg_data[ROW_BITS-1:0];
                REG_ROT_Y:   cfg_reg.rot[1]   <= cfg_data[ROW_BITS-1:0];
                REG_ROT_Z:   cfg_reg.rot[2]   <= cfg_data[ROW_BITS-1:0];
                REG_SHIFT_X: cfg_reg.shift[0] <= cfg_data[COORD_BITS-1:0];
                REG_SHIFT_Y: cfg_reg.shift[1] <= cfg_data[COORD_BITS-1:0];
                REG_SHIFT_Z: cfg_reg.shift[2] <= cfg_data[COORD_BITS-1:0];
                REG_REACH:   cfg_reg.lim2 <= LIM2_BITS'(lim_next) * LIM2_BITS'(lim_next);
                REG_FOV:
                begin
                    cfg_reg.tan_h <= cfg_data[TAN_BITS-1:0];
                    cfg_reg.tv2   <= TV2_BITS'(tan_v_next) * TV2_BITS'(tan_v_next);
                end
                default: cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/core/sfpc_xform.sv
// Two-stage world-to-sensor transform: nine products, then row sums with rounding and shift.
// Uses sfpc_pkg for widths and the sens_t result type.
module sfpc_xform
    import sfpc_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  cfg_t                         cfg,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] world_x,
    input  logic signed [COORD_BITS-1:0] world_y,
    input  logic signed [COORD_BITS-1:0] world_z,
    output logic                         out_valid,
    input  logic                         out_ready,
    output sens_t                        sens
);

    localparam logic signed [ACC_BITS-1:0] ROUND_HALF =
        {{(ACC_BITS - ROT_FRAC_BITS){1'b0}}, 1'b1, {(ROT_FRAC_BITS - 1){1'b0}}};

    logic [1:0]                   vld_reg;
    logic [1:0]                   en;
    logic signed [COORD_BITS-1:0] coord [3];
    logic signed [PROD_BITS-1:0]  prod_reg [3][3];
    point_t                       pt_reg;
    sens_t                        sens_reg;
    sens_t                        sens_next;
    logic signed [ACC_BITS-1:0]   acc_next [3];
    logic signed [SENS_BITS-1:0]  row_next [3];

    assign coord[0] = world_x;
    assign coord[1] = world_y;
    assign coord[2] = world_z;

    assign en[1]    = !vld_reg[1] || out_ready;
    assign en[0]    = !vld_reg[0] || en[1];
    assign in_ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= in_valid;
            end
            if (en[1])
            begin
                vld_reg[1] <= vld_reg[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    prod_reg[i][j] <= $signed(cfg.rot[i][j]) * coord[j];
                end
            end
            pt_reg.x <= world_x;
            pt_reg.y <= world_y;
            pt_reg.z <= world_z;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            acc_next[i] = ACC_BITS'(prod_reg[i][0]) + ACC_BITS'(prod_reg[i][1])
                        + ACC_BITS'(prod_reg[i][2]) + ROUND_HALF;
            row_next[i] = SENS_BITS'($signed(acc_next[i][ACC_BITS-1:ROT_FRAC_BITS]))
                        + SENS_BITS'($signed(cfg.shift[i]));
        end
        sens_next.x  = row_next[0];
        sens_next.y  = row_next[1];
        sens_next.z  = row_next[2];
        sens_next.pt = pt_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            sens_reg <= sens_next;
        end
    end

    assign out_valid = vld_reg[1];
    assign sens      = sens_reg;

endmodule

// File: rtl/core/sfpc_test.sv
// Five-stage frustum test: squares, range and horizontal compares, split vertical product,
// then its sum and the ordered reject decision in the output register. Uses sfpc_pkg.
module sfpc_test
    import sfpc_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  cfg_t                          cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  sens_t                         sens,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          keep,
    output logic [2:0]                    reject_reason,
    output point_t                        pt
);

    localparam int NS = 5;

    logic [NS-1:0] vld_reg;
    logic [NS-1:0] en;

    logic [MAG_BITS-1:0]  ax_next;
    logic [MAG_BITS-1:0]  ay_next;
    logic [MAG_BITS-1:0]  az_next;
    logic signed [SENS_BITS-1:0] negx_next;
    logic signed [SENS_BITS-1:0] negy_next;
    logic signed [SENS_BITS-1:0] negz_next;
    logic                 behind_next;

    logic [SQ_BITS-1:0]   sqx_reg;
    logic [SQ_BITS-1:0]   sqy_reg;
    logic [SQ_BITS-1:0]   sqz_reg;
    logic [HT_BITS-1:0]   hprod_reg;
    logic [MAG_BITS-1:0]  ay_reg;
    logic                 bh3_reg;
    point_t               pt3_reg;

    logic [XY2_BITS-1:0]  xy2_next;
    logic [R2_BITS-1:0]   r2_next;
    logic [XY2_BITS-1:0]  xy2_reg;
    logic [SQ_BITS-1:0]   az2_4_reg;
    logic                 rf4_reg;
    logic                 bh4_reg;
    logic                 hf4_reg;
    point_t               pt4_reg;

    logic [PP_LO-1:0]     pp_ll_reg;
    logic [PP_LO-1:0]     pp_lh_reg;
    logic [PP_HI-1:0]     pp_hl_reg;
    logic [PP_HI-1:0]     pp_hh_reg;
    logic [SQ_BITS-1:0]   az2_5_reg;
    logic                 rf5_reg;
    logic                 bh5_reg;
    logic                 hf5_reg;
    point_t               pt5_reg;

    logic [RHS_BITS-1:0]  rhs_next;
    logic [RHS_BITS-1:0]  rhs_reg;
    logic [SQ_BITS-1:0]   az2_6_reg;
    logic                 rf6_reg;
    logic                 bh6_reg;
    logic                 hf6_reg;
    point_t               pt6_reg;

    logic [RHS_BITS-1:0]  lhs_next;
    logic                 vf_next;
    reason_t              reason_next;
    reason_t              reason_reg;
    logic                 keep_reg;
    point_t               pt7_reg;

    always_comb
    begin
        en[NS-1] = !vld_reg[NS-1] || out_ready;
        for (int i = NS - 2; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    assign in_ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // Magnitudes and the behind test come straight from the sensor-frame point.
    always_comb
    begin
        negx_next   = -sens.x;
        negy_next   = -sens.y;
        negz_next   = -sens.z;
        ax_next     = sens.x[SENS_BITS-1] ? negx_next[MAG_BITS-1:0] : sens.x[MAG_BITS-1:0];
        ay_next     = sens.y[SENS_BITS-1] ? negy_next[MAG_BITS-1:0] : sens.y[MAG_BITS-1:0];
        az_next     = sens.z[SENS_BITS-1] ? negz_next[MAG_BITS-1:0] : sens.z[MAG_BITS-1:0];
        behind_next = sens.x[SENS_BITS-1] || (sens.x == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            sqx_reg   <= SQ_BITS'(ax_next) * SQ_BITS'(ax_next);
            sqy_reg   <= SQ_BITS'(ay_next) * SQ_BITS'(ay_next);
            sqz_reg   <= SQ_BITS'(az_next) * SQ_BITS'(az_next);
            hprod_reg <= HT_BITS'(cfg.tan_h) * HT_BITS'(ax_next);
            ay_reg    <= ay_next;
            bh3_reg   <= behind_next;
            pt3_reg   <= sens.pt;
        end
    end

    always_comb
    begin
        xy2_next = XY2_BITS'(sqx_reg) + XY2_BITS'(sqy_reg);
        r2_next  = R2_BITS'(xy2_next) + R2_BITS'(sqz_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            xy2_reg   <= xy2_next;
            az2_4_reg <= sqz_reg;
            rf4_reg   <= r2_next > R2_BITS'(cfg.lim2);
            bh4_reg   <= bh3_reg;
            hf4_reg   <= HT_BITS'({ay_reg, {TAN_FRAC_BITS{1'b0}}}) > hprod_reg;
            pt4_reg   <= pt3_reg;
        end
    end

    // The vertical right-hand side is split into four partial products.
    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            pp_ll_reg <= PP_LO'(xy2_reg[XY2_LO-1:0]) * PP_LO'(cfg.tv2[TAN_BITS-1:0]);
            pp_lh_reg <= PP_LO'(xy2_reg[XY2_LO-1:0]) * PP_LO'(cfg.tv2[TV2_BITS-1:TAN_BITS]);
            pp_hl_reg <= PP_HI'(xy2_reg[XY2_BITS-1:XY2_LO]) * PP_HI'(cfg.tv2[TAN_BITS-1:0]);
            pp_hh_reg <= PP_HI'(xy2_reg[XY2_BITS-1:XY2_LO])
                       * PP_HI'(cfg.tv2[TV2_BITS-1:TAN_BITS]);
            az2_5_reg <= az2_4_reg;
            rf5_reg   <= rf4_reg;
            bh5_reg   <= bh4_reg;
            hf5_reg   <= hf4_reg;
            pt5_reg   <= pt4_reg;
        end
    end

    assign rhs_next = RHS_BITS'(pp_ll_reg)
                    + (RHS_BITS'(pp_lh_reg) << TAN_BITS)
                    + (RHS_BITS'(pp_hl_reg) << XY2_LO)
                    + (RHS_BITS'(pp_hh_reg) << (XY2_LO + TAN_BITS));

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            rhs_reg   <= rhs_next;
            az2_6_reg <= az2_5_reg;
            rf6_reg   <= rf5_reg;
            bh6_reg   <= bh5_reg;
            hf6_reg   <= hf5_reg;
            pt6_reg   <= pt5_reg;
        end
    end

    always_comb
    begin
        lhs_next = RHS_BITS'(az2_6_reg) << (2 * TAN_FRAC_BITS);
        vf_next  = lhs_next > rhs_reg;
        if (rf6_reg)
        begin
            reason_next = RSN_RANGE;
        end
        else if (bh6_reg)
        begin
            reason_next = RSN_BEHIND;
        end
        else if (hf6_reg)
        begin
            reason_next = RSN_HFOV;
        end
        else if (vf_next)
        begin
            reason_next = RSN_VFOV;
        end
        else
        begin
            reason_next = RSN_KEEP;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            reason_reg <= reason_next;
            keep_reg   <= (reason_next == RSN_KEEP);
            pt7_reg    <= pt6_reg;
        end
    end

    assign out_valid     = vld_reg[NS-1];
    assign keep          = keep_reg;
    assign reject_reason = reason_reg;
    assign pt            = pt7_reg;

endmodule

// File: rtl/core/sensor_frustum_point_cull_top.sv
// Sensor view-frustum point cull: one world-frame point in, one keep/reject request out.
//
// Configuration: cfg_write/cfg_index/cfg_data write one register per cycle, with no wait
// and no read-back. Rotation rows, translation, range limit and the two Q8.16 half-field
// tangents take effect for points accepted after the write; write only while idle.
// Input: a request is taken when in_valid and in_ready are both high; world_x/y/z are
// signed Q13.10 metres.
// Output: a request is delivered when out_valid and out_ready are both high. keep,
// reject_reason (kept, range, behind, horizontal, vertical) and the original point.
// A request passes through seven register stages from input acceptance to out_valid:
// two transform stages (products, then rounded row sums) and five test stages (squares,
// compares, split vertical product, its sum, final decision). Throughput is one point
// per cycle while out_ready stays high.
// When the receiver stalls, each stage holds its request; empty stages still fill, so
// input is taken until the pipeline is full, and nothing is lost or repeated.
// Reset clears all valid bits and returns the configuration to identity rotation, zero
// translation, maximum range and unit tangents.
module sensor_frustum_point_cull_top
    import sfpc_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic [CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [CFG_DATA_BITS-1:0]     cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] world_x,
    input  logic signed [COORD_BITS-1:0] world_y,
    input  logic signed [COORD_BITS-1:0] world_z,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         keep,
    output logic [2:0]                   reject_reason,
    output logic signed [COORD_BITS-1:0] out_x,
    output logic signed [COORD_BITS-1:0] out_y,
    output logic signed [COORD_BITS-1:0] out_z
);

    cfg_t   cfg;
    sens_t  sens;
    logic   sens_valid;
    logic   sens_ready;
    point_t pt;

    sfpc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sfpc_xform u_xform (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .world_x   (world_x),
        .world_y   (world_y),
        .world_z   (world_z),
        .out_valid (sens_valid),
        .out_ready (sens_ready),
        .sens      (sens)
    );

    sfpc_test u_test (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .in_valid      (sens_valid),
        .in_ready      (sens_ready),
        .sens          (sens),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .keep          (keep),
        .reject_reason (reject_reason),
        .pt            (pt)
    );

    assign out_x = pt.x;
    assign out_y = pt.y;
    assign out_z = pt.z;

endmodule
